### rtl/core/lfoc_pkg.sv
// lfoc_pkg: shared constants, types and the sine table generator for the chorus block
// no dependencies; imported by lfoc_sine, lfoc_mul and the top level

package lfoc_pkg;

	// default sizes handed to the top level parameters
	localparam int unsigned MAX_DELAY_DEF    = 2048;
	localparam int unsigned SINE_ENTRIES_DEF = 1024;
	localparam int unsigned SAMPLE_BITS_DEF  = 16;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 2'd2;

	// register widths and reset values
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned STEP_W     = 32;
	localparam int unsigned DEPTH_W    = 17;
	localparam int unsigned LENGTH_W   = 12;
	localparam logic [STEP_W-1:0]   PHASE_STEP_RST   = 32'd48695;
	localparam logic [DEPTH_W-1:0]  MOD_DEPTH_RST    = 17'd19661;
	localparam logic [LENGTH_W-1:0] DELAY_LENGTH_RST = 12'd882;
	localparam logic [DEPTH_W-1:0]  DEPTH_ONE        = 17'd65536;

	// lfo and mix arithmetic
	localparam int unsigned PHASE_W = 32;
	localparam int unsigned LFO_W   = 16;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic signed [17:0] MIX_DRY = 18'sd22938;
	localparam logic signed [17:0] MIX_WET = 18'sd9830;
	localparam int unsigned MIX_SHIFT = 15;

	// shared multiplier operand and product widths
	localparam int unsigned MUL_A_W = 18;
	localparam int unsigned MUL_B_W = 33;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	typedef struct packed {
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_op_t;

	// first-quadrant sine entry k (Q1.15) of a table with 2**idx_bits entries,
	// Q30 Taylor series up to x^9, rounded and clamped; elaboration only
	function automatic logic signed [LFO_W-1:0] sine_quarter(input int unsigned k,
			input int unsigned idx_bits);
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t3;
		logic [63:0] t5;
		logic [63:0] t7;
		logic [63:0] t9;
		logic signed [63:0] s;
		logic [63:0] q;
		r  = 64'(k) << (32 - idx_bits);
		x  = (r * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		t3 = ((x * x2) >> 30) / 64'd6;
		t5 = ((t3 * x2) >> 30) / 64'd20;
		t7 = ((t5 * x2) >> 30) / 64'd42;
		t9 = ((t7 * x2) >> 30) / 64'd72;
		s  = $signed(x - t3 + t5 - t7 + t9);
		if (s < 0) begin
			s = 64'sd0;
		end
		q = ($unsigned(s) + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return $signed(q[LFO_W-1:0]);
	endfunction

endpackage

### rtl/core/lfoc_ram.sv
// lfoc_ram: generic single write, single read RAM with registered read data
// no dependencies

module lfoc_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/lfoc_sine.sv
// lfoc_sine: quarter-wave sine table with quadrant folding and registered output
// depends on lfoc_pkg (sine_quarter, LFO_W); table size must be a power of two

module lfoc_sine #(
	parameter int unsigned SINE_ENTRIES = lfoc_pkg::SINE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [$clog2(SINE_ENTRIES)-1:0] idx,
	output logic signed [lfoc_pkg::LFO_W-1:0] lfo
);

	import lfoc_pkg::*;

	localparam int unsigned IDX_W  = $clog2(SINE_ENTRIES);
	localparam int unsigned QA_W   = IDX_W - 1;
	localparam int unsigned QUART  = SINE_ENTRIES / 4;
	localparam int unsigned HALF   = SINE_ENTRIES / 2;
	localparam int unsigned QDEPTH = QUART + 1;

	logic signed [LFO_W-1:0] rom [QDEPTH];
	logic [QA_W-1:0]         kp;
	logic [QA_W-1:0]         addr;
	logic                    neg;

	for (genvar k = 0; k < QDEPTH; k++) begin : g_rom
		assign rom[k] = sine_quarter(k, IDX_W);
	end

	// second quarter mirrors the first, second half flips sign
	always_comb begin
		neg = idx[IDX_W-1];
		kp  = idx[QA_W-1:0];
		if (32'(kp) > QUART) begin
			addr = QA_W'(IDX_W'(HALF) - IDX_W'(kp));
		end else begin
			addr = kp;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lfo <= neg ? -rom[addr] : rom[addr];
		end
	end

endmodule

### rtl/core/lfoc_mul.sv
// lfoc_mul: shared signed multiplier with registered product
// depends on lfoc_pkg (mul_op_t, MUL_P_W)

module lfoc_mul (
	input  logic                                clk,
	input  logic                                en,
	input  lfoc_pkg::mul_op_t                   op,
	output logic signed [lfoc_pkg::MUL_P_W-1:0] prod
);

	import lfoc_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			prod <= op.a * op.b;
		end
	end

endmodule

### rtl/core/lfo_modulated_delay_chorus.sv
// lfo_modulated_delay_chorus: sine lfo chorus on a circular delay line, top level
// depends on lfoc_pkg, lfoc_ram, lfoc_sine and lfoc_mul
//
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+-----------------------------
// input    | in        | in_valid / in_ready    | sample_in  (signed Q1.15)
// output   | out       | out_valid / out_ready  | sample_out (signed Q1.15)
// config   | in        | cfg_we (no wait)       | cfg_idx, cfg_wdata
//
// each sample passes through the transfer in idle, then lfo lookup, depth and
// delay products, address, delay line write and read, and two mix products,
// all four products on one shared multiplier between registered memory reads
// after reset the delay line is cleared, one entry a cycle, across all MAX_DELAY
// entries; in_ready stays low meanwhile, config writes are taken throughout
// a finished sample waits in the output register; while it is not taken the
// next sample is still accepted and only its final mix cycle stalls

module lfo_modulated_delay_chorus #(
	parameter int unsigned MAX_DELAY    = lfoc_pkg::MAX_DELAY_DEF,
	parameter int unsigned SINE_ENTRIES = lfoc_pkg::SINE_ENTRIES_DEF,
	parameter int unsigned SAMPLE_BITS  = lfoc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [SAMPLE_BITS-1:0]      sample_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	input  logic                               cfg_we,
	input  logic [lfoc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [lfoc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	import lfoc_pkg::*;

	localparam int unsigned PTR_W = $clog2(MAX_DELAY);
	localparam int unsigned LEN_W = $clog2(MAX_DELAY + 1);
	localparam int unsigned IDX_W = $clog2(SINE_ENTRIES);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LFO,
		S_SCALE,
		S_DLY,
		S_ADDR,
		S_READ,
		S_MIX1,
		S_MIX2
	} state_t;

	state_t state_q;

	// configuration registers
	logic [STEP_W-1:0]   phase_step_q;
	logic [DEPTH_W-1:0]  mod_depth_q;
	logic [LENGTH_W-1:0] delay_length_q;

	// per-sample working registers
	logic [PHASE_W-1:0]          phase_q;
	logic [PTR_W-1:0]            pos_q;
	logic [PTR_W-1:0]            clr_q;
	logic [LEN_W-1:0]            len_q;
	logic [DEPTH_W-1:0]          depth_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [31:0]                 scale_q;
	logic [PTR_W-1:0]            rd_q;
	logic signed [MUL_P_W-1:0]   acc_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                        out_valid_q;

	// datapath nets
	logic                        in_xfer;
	logic [LEN_W-1:0]            len_new;
	logic [PTR_W-1:0]            pos_start;
	logic [LEN_W-1:0]            half;
	logic [LEN_W-1:0]            dly_raw;
	logic [LEN_W-1:0]            dly;
	logic [LEN_W:0]              rd_sum;
	logic [LEN_W:0]              rd_wrap;
	logic [PTR_W:0]              pos_inc;
	logic signed [MUL_P_W-1:0]   mix_sum;

	logic signed [LFO_W-1:0]     lfo;
	logic                        mul_en;
	mul_op_t                     mul_op;
	logic signed [MUL_P_W-1:0]   prod;

	logic                        ram_we;
	logic [PTR_W-1:0]            ram_waddr;
	logic [SAMPLE_BITS-1:0]      ram_wdata;
	logic                        ram_re;
	logic [SAMPLE_BITS-1:0]      ram_rdata;

	assign in_ready   = (state_q == S_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// config write port, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= PHASE_STEP_RST;
			mod_depth_q    <= MOD_DEPTH_RST;
			delay_length_q <= DELAY_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PHASE_STEP:   phase_step_q   <= cfg_wdata[STEP_W-1:0];
				REG_MOD_DEPTH:    mod_depth_q    <= cfg_wdata[DEPTH_W-1:0];
				REG_DELAY_LENGTH: delay_length_q <= cfg_wdata[LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	// length in use is clamped to [2, MAX_DELAY]; a stale position restarts at 0
	always_comb begin
		if (delay_length_q < LENGTH_W'(2)) begin
			len_new = LEN_W'(2);
		end else if (32'(delay_length_q) > MAX_DELAY) begin
			len_new = LEN_W'(MAX_DELAY);
		end else begin
			len_new = LEN_W'(delay_length_q);
		end
		if (32'(pos_q) >= 32'(len_new)) begin
			pos_start = '0;
		end else begin
			pos_start = pos_q;
		end
	end

	// delay = (half * scale) >> 31, capped below the length
	// read index = pos + len - delay, wrapped once
	always_comb begin
		half    = len_q >> 1;
		dly_raw = prod[31 +: LEN_W];
		if (dly_raw >= len_q) begin
			dly = len_q - LEN_W'(1);
		end else begin
			dly = dly_raw;
		end
		rd_sum  = (LEN_W+1)'(pos_q) + (LEN_W+1)'(len_q) - (LEN_W+1)'(dly);
		rd_wrap = (rd_sum >= (LEN_W+1)'(len_q)) ? rd_sum - (LEN_W+1)'(len_q) : rd_sum;
		pos_inc = (PTR_W+1)'(pos_q) + (PTR_W+1)'(1);
		mix_sum = acc_q + prod;
	end

	// shared multiplier operand select
	always_comb begin
		mul_en   = 1'b0;
		mul_op.a = '0;
		mul_op.b = '0;
		unique case (state_q)
			S_LFO: begin
				mul_en   = 1'b1;
				mul_op.a = MUL_A_W'(lfo);
				mul_op.b = $signed(MUL_B_W'(depth_q));
			end
			S_DLY: begin
				mul_en   = 1'b1;
				mul_op.a = $signed(MUL_A_W'(half));
				mul_op.b = $signed(MUL_B_W'(scale_q));
			end
			S_READ: begin
				mul_en   = 1'b1;
				mul_op.a = MIX_DRY;
				mul_op.b = MUL_B_W'(x_q);
			end
			S_MIX1: begin
				mul_en   = 1'b1;
				mul_op.a = MIX_WET;
				mul_op.b = MUL_B_W'($signed(ram_rdata));
			end
			default: ;
		endcase
	end

	// delay line port: clearing sweep after reset, else the sample write
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = x_q;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == S_ADDR) begin
			ram_we = 1'b1;
		end
		ram_re = (state_q == S_READ);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			phase_q      <= '0;
			pos_q        <= '0;
			out_valid_q  <= 1'b0;
			len_q        <= '0;
			depth_q      <= '0;
			x_q          <= '0;
			scale_q      <= '0;
			rd_q         <= '0;
			acc_q        <= '0;
			sample_out_q <= '0;
		end else begin
			// the final mix cycle handles its own result transfer
			if (out_valid_q && out_ready && state_q != S_MIX2) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + PTR_W'(1);
					if (clr_q == PTR_W'(MAX_DELAY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						x_q     <= sample_in;
						len_q   <= len_new;
						depth_q <= (mod_depth_q > DEPTH_ONE) ? DEPTH_ONE : mod_depth_q;
						pos_q   <= pos_start;
						phase_q <= phase_q + phase_step_q;
						state_q <= S_LFO;
					end
				end
				S_LFO: begin
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					// true value lies in [0, 2^32), so modular add is exact
					scale_q <= 32'h8000_0000 + prod[31:0];
					state_q <= S_DLY;
				end
				S_DLY: begin
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					rd_q    <= PTR_W'(rd_wrap);
					state_q <= S_READ;
				end
				S_READ: begin
					if (32'(pos_inc) >= 32'(len_q)) begin
						pos_q <= '0;
					end else begin
						pos_q <= PTR_W'(pos_inc);
					end
					state_q <= S_MIX1;
				end
				S_MIX1: begin
					acc_q   <= prod;
					state_q <= S_MIX2;
				end
				S_MIX2: begin
					// floor of the Q15 mix, waits while the last result is unclaimed
					if (!out_valid_q || out_ready) begin
						sample_out_q <= mix_sum[MIX_SHIFT +: SAMPLE_BITS];
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	lfoc_sine #(
		.SINE_ENTRIES(SINE_ENTRIES)
	) u_sine (
		.clk(clk),
		.en (in_xfer),
		.idx(phase_q[PHASE_W-1 -: IDX_W]),
		.lfo(lfo)
	);

	lfoc_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.op  (mul_op),
		.prod(prod)
	);

	lfoc_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_DELAY)
	) u_delay_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_q),
		.rdata(ram_rdata)
	);

endmodule
